### rtl/qoi_pkg.sv
// ============================================================================
// qoi_pkg: shared types and constants for the QOI stream encoder
// Pixel word layout, chunk tags and table geometry.
// ============================================================================
`default_nettype none
package qoi_pkg;
    localparam int TableEntries = 64;
    localparam int HashW        = $clog2(TableEntries);
    localparam int PixW         = 32;
    localparam logic [7:0] RunMax  = 8'd62;
    localparam logic [7:0] TagRun  = 8'hC0;
    localparam logic [7:0] TagDiff = 8'h40;
    localparam logic [7:0] TagLuma = 8'h80;
    localparam logic [7:0] TagRgb  = 8'hFE;
    localparam logic [7:0] TagRgba = 8'hFF;
    localparam logic [PixW-1:0] PixReset = 32'h000000FF;

    localparam logic [1:0] CfgWidth  = 2'd0;
    localparam logic [1:0] CfgHeight = 2'd1;
    localparam logic [1:0] CfgChan   = 2'd2;
    localparam logic [1:0] CfgSpace  = 2'd3;

    // (3r + 5g + 7b + 11a) mod 64
    function automatic logic [HashW-1:0] qoi_hash(input logic [PixW-1:0] px);
        logic [11:0] s;
        s = 12'(px[31:24]) * 12'd3 + 12'(px[23:16]) * 12'd5
          + 12'(px[15:8]) * 12'd7 + 12'(px[7:0]) * 12'd11;
        return s[HashW-1:0];
    endfunction
endpackage
`default_nettype wire

### rtl/qoi_ram.sv
// ============================================================================
// qoi_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none
module qoi_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/qoi_pixel_stream_encoder_core.sv
// ============================================================================
// qoi_pixel_stream_encoder_core: QOI byte stream encoder
// Header, run/index/diff/luma/rgb/rgba chunks and end marker, one byte out
// per cycle while i_ready is high.
// ============================================================================
// channel | signals                                | role
// pixel   | i_valid/o_ready, i_red..i_final_pixel  | input transaction
// bytes   | o_valid/i_ready, o_out_byte, flags     | output transaction
// config  | i_cfg_we, i_cfg_index, i_cfg_data      | register write
//
// Stage 1 registers the pixel and issues the color table read (hash index).
// Stage 2 gets the table word (forwarded from the stage-2 write of the prior
// pixel when the hash matches or it was cleared), picks the chunk and loads a
// byte buffer of up to 27 bytes. The buffer drains one byte per cycle while
// i_ready is high. After reset or an end marker, a sweep clears all 64 table
// entries while o_ready is low. Output stall holds the buffer; the stage-1
// register takes the next pixel as soon as stage 2 frees up.
`default_nettype none
module qoi_pixel_stream_encoder_core
    import qoi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [7:0]  i_alpha,
    input  wire logic        i_final_pixel,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_burst_last,
    output logic             o_image_done
);
    localparam int BufN = 27;
    localparam int CntW = $clog2(BufN + 1);

    // config
    logic [15:0] r_width, r_height;
    logic [2:0]  r_chan;
    logic        r_space;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 16'd75; r_height <= 16'd50; r_chan <= 3'd3; r_space <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgWidth:  r_width  <= i_cfg_data;
                CfgHeight: r_height <= i_cfg_data;
                CfgChan:   r_chan   <= i_cfg_data[2:0];
                CfgSpace:  r_space  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clear sweep
    logic             r_clr;
    logic [HashW:0]   r_clr_cnt;

    // stage 1
    logic             r_s1_v;
    logic [PixW-1:0]  r_s1_px;
    logic             r_s1_last;
    logic [HashW-1:0] r_s1_h;

    // byte buffer
    logic [7:0]       r_buf [BufN];
    logic [CntW-1:0]  r_cnt, r_pos;
    logic             r_done_flag;

    // encoder state
    logic [PixW-1:0]  r_prev;
    logic [5:0]       r_run;
    logic             r_hdr;

    logic             s2_go, s2_free;
    logic [PixW-1:0]  tbl_rd, tbl_word;
    logic             r_fwd_v;
    logic [HashW-1:0] r_fwd_h;
    logic [PixW-1:0]  r_fwd_px;

    assign s2_free = (r_cnt == '0) || (r_pos == r_cnt - 1'b1 && i_ready);
    assign s2_go   = r_s1_v && s2_free;
    assign o_ready = !r_clr && (!r_s1_v || s2_go) && !(r_s1_v && r_s1_last);

    logic s1_take;
    assign s1_take = i_valid && o_ready;

    logic [PixW-1:0]  in_px;
    assign in_px = {i_red, i_green, i_blue, i_alpha};

    // table write from stage 2
    logic             tw_e;
    logic [HashW-1:0] tw_a;
    logic [PixW-1:0]  tw_d;

    qoi_ram #(.Width(PixW), .Depth(TableEntries)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (tw_e),
        .i_waddr(tw_a),
        .i_wdata(tw_d),
        .i_raddr(s1_take ? qoi_hash(in_px) : r_s1_h),
        .o_rdata(tbl_rd)
    );

    // read is issued each cycle at stage-1 hash; forward the write made in the
    // same cycle as the read
    always_ff @(posedge i_clk) begin
        r_fwd_v  <= tw_e && (tw_a == (s1_take ? qoi_hash(in_px) : r_s1_h));
        r_fwd_h  <= tw_a;
        r_fwd_px <= tw_d;
    end
    assign tbl_word = (r_fwd_v && r_fwd_h == r_s1_h) ? r_fwd_px : tbl_rd;

    // chunk selection
    logic [7:0] nb [BufN];
    logic [CntW-1:0] n_cnt;
    logic [5:0]  n_run;
    logic        n_store;
    logic [7:0]  dr, dg, db, drg, dbg;
    logic        small_d, luma_ok;
    logic [7:0]  pr, pg, pbb, pa, cr, cg, cb, ca;

    always_comb begin
        {cr, cg, cb, ca} = r_s1_px;
        {pr, pg, pbb, pa} = r_prev;
        dr  = cr - pr;
        dg  = cg - pg;
        db  = cb - pbb;
        drg = dr - dg;
        dbg = db - dg;
        small_d = (dr + 8'd2 < 8'd4) && (dg + 8'd2 < 8'd4) && (db + 8'd2 < 8'd4);
        luma_ok = (dg + 8'd32 < 8'd64) && (drg + 8'd8 < 8'd16) && (dbg + 8'd8 < 8'd16);
        for (int k = 0; k < BufN; k++) nb[k] = 8'h00;
        n_cnt   = '0;
        n_run   = r_run;
        n_store = 1'b0;
        if (!r_hdr) begin
            nb[0] = 8'h71; nb[1] = 8'h6F; nb[2] = 8'h69; nb[3] = 8'h66;
            nb[6] = r_width[15:8];  nb[7]  = r_width[7:0];
            nb[10] = r_height[15:8]; nb[11] = r_height[7:0];
            nb[12] = {5'd0, r_chan};
            nb[13] = {7'd0, r_space};
            n_cnt = CntW'(14);
        end
        if (r_s1_px == r_prev) begin
            n_run = r_run + 6'd1;
            if (n_run == RunMax[5:0]) begin
                nb[n_cnt] = TagRun | {2'b00, n_run - 6'd1};
                n_cnt = n_cnt + 1'b1;
                n_run = '0;
            end
        end else begin
            if (r_run != '0) begin
                nb[n_cnt] = TagRun | {2'b00, r_run - 6'd1};
                n_cnt = n_cnt + 1'b1;
                n_run = '0;
            end
            if (tbl_word == r_s1_px) begin
                nb[n_cnt] = {2'b00, r_s1_h};
                n_cnt = n_cnt + 1'b1;
            end else begin
                n_store = 1'b1;
                if (ca == pa) begin
                    if (small_d) begin
                        nb[n_cnt] = TagDiff | {2'b00, dr[1:0] + 2'd2, dg[1:0] + 2'd2,
                                               db[1:0] + 2'd2};
                        n_cnt = n_cnt + 1'b1;
                    end else if (luma_ok) begin
                        nb[n_cnt] = TagLuma | {2'b00, dg[5:0] + 6'd32};
                        nb[n_cnt + 1'b1] = {drg[3:0] + 4'd8, dbg[3:0] + 4'd8};
                        n_cnt = n_cnt + CntW'(2);
                    end else begin
                        nb[n_cnt] = TagRgb; nb[n_cnt + 1'b1] = cr;
                        nb[n_cnt + CntW'(2)] = cg; nb[n_cnt + CntW'(3)] = cb;
                        n_cnt = n_cnt + CntW'(4);
                    end
                end else begin
                    nb[n_cnt] = TagRgba; nb[n_cnt + 1'b1] = cr;
                    nb[n_cnt + CntW'(2)] = cg; nb[n_cnt + CntW'(3)] = cb;
                    nb[n_cnt + CntW'(4)] = ca;
                    n_cnt = n_cnt + CntW'(5);
                end
            end
        end
        if (r_s1_last) begin
            if (n_run != '0) begin
                nb[n_cnt] = TagRun | {2'b00, n_run - 6'd1};
                n_cnt = n_cnt + 1'b1;
            end
            n_cnt = n_cnt + CntW'(7);
            nb[n_cnt] = 8'h01;
            n_cnt = n_cnt + 1'b1;
        end
    end

    always_comb begin
        tw_e = 1'b0; tw_a = r_s1_h; tw_d = r_s1_px;
        if (r_clr) begin
            tw_e = 1'b1; tw_a = r_clr_cnt[HashW-1:0]; tw_d = '0;
        end else if (s2_go && n_store) begin
            tw_e = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_cnt <= '0; r_pos <= '0; r_done_flag <= 1'b0;
            r_prev <= PixReset; r_run <= '0; r_hdr <= 1'b0;
            r_clr <= 1'b1; r_clr_cnt <= '0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == (HashW+1)'(TableEntries - 1)) r_clr <= 1'b0;
            end
            if (r_cnt != '0 && i_ready) begin
                if (r_pos == r_cnt - 1'b1) begin
                    r_cnt <= '0; r_pos <= '0;
                end else r_pos <= r_pos + 1'b1;
            end
            if (s2_go) begin
                r_s1_v <= 1'b0;
                r_cnt  <= n_cnt; r_pos <= '0;
                r_done_flag <= r_s1_last;
                for (int k = 0; k < BufN; k++) r_buf[k] <= nb[k];
                if (r_s1_last) begin
                    r_prev <= PixReset; r_run <= '0; r_hdr <= 1'b0;
                    r_clr <= 1'b1; r_clr_cnt <= '0;
                end else begin
                    r_prev <= r_s1_px; r_run <= n_run; r_hdr <= 1'b1;
                end
            end
            if (s1_take) r_s1_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_s1_px <= in_px; r_s1_last <= i_final_pixel; r_s1_h <= qoi_hash(in_px);
        end
    end

    assign o_valid      = r_cnt != '0;
    assign o_out_byte   = r_buf[r_pos[CntW-1:0]];
    assign o_burst_last = r_pos == r_cnt - 1'b1;
    assign o_image_done = o_burst_last && r_done_flag;
endmodule
`default_nettype wire
